// File: rtl/core/cll_pkg.sv
package cll_pkg;

	// request actions
	localparam logic [1:0] ACT_INSERT    = 2'd0;
	localparam logic [1:0] ACT_FIND      = 2'd1;
	localparam logic [1:0] ACT_FIND_PREV = 2'd2;
	localparam logic [1:0] ACT_REMOVE    = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_BAD_POS   = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] value;
		logic [6:0]  position;
	} request_t;

	typedef struct packed {
		logic [6:0] result_position;
		logic       found;
		logic [1:0] status;
		logic       list_empty;
	} result_t;

endpackage

// File: rtl/core/cursor_linked_list_engine.sv
// cursor linked list engine: a singly linked list with a free list in a node store
//
// request channel: request is taken at a rising edge where start is high and busy
// is low. actions are insert after a node, find a value, find the node before a
// value, and remove the first node holding a value.
// result channel: exactly one result per request, shown for one cycle while
// result_valid is high. the receiver cannot stall, so nothing is held back.
// sequence: a walk visits one list node per cycle, limited by the registered read
// of the link/value memories. find and find previous answer at the first hit, or
// at the end of the list on a miss (with no walk on an empty list), remove adds
// the unlink and free write-back states, insert adds the read, link and hook
// states after the walk to its position (no walk when inserting after the header).
// busy drops in the cycle the result is shown, so the next request can be taken
// there.
// reset: the free chain 2 -> 3 -> ... -> last is written into the link memory,
// one entry per cycle, after reset; busy is high
// during that sweep. the list starts empty. node values are unset until inserted.
// free-list head and first list node live in registers, not in the memory.
module cursor_linked_list_engine #(
	parameter int NODE_COUNT = 128,
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  cll_pkg::request_t  request,
	output logic               result_valid,
	output cll_pkg::result_t   result
);

	localparam int IDX_W = $clog2(NODE_COUNT);
	localparam logic [IDX_W-1:0] NULL_NODE   = '0;
	localparam logic [IDX_W-1:0] HEADER_NODE = IDX_W'(1);
	localparam logic [IDX_W-1:0] FIRST_FREE  = IDX_W'(2);
	localparam logic [IDX_W-1:0] LAST_NODE   = IDX_W'(NODE_COUNT - 1);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_WALK,
		S_INS_RD,
		S_INS_LINK,
		S_INS_HOOK,
		S_RM_UNLINK,
		S_RM_FREE
	} state_t;

	state_t state_q;

	// node store: links and values, one read and one write port each
	logic [IDX_W-1:0]      link_mem [NODE_COUNT];
	logic [VALUE_BITS-1:0] val_mem  [NODE_COUNT];
	logic [IDX_W-1:0]      link_rd_q;
	logic [VALUE_BITS-1:0] val_rd_q;

	// list heads kept outside the memory
	logic [IDX_W-1:0] free_q;
	logic [IDX_W-1:0] first_q;

	// request context
	logic [1:0]            action_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [IDX_W-1:0]      pos_q;
	logic [IDX_W-1:0]      cur_q;
	logic [IDX_W-1:0]      prev_q;
	logic [IDX_W-1:0]      plink_q;
	logic [IDX_W-1:0]      init_q;

	cll_pkg::result_t result_q;
	logic             result_valid_q;

	logic                  accept;
	logic                  walk_hit;
	logic [VALUE_BITS-1:0] req_value;
	logic [IDX_W-1:0]      req_pos;
	logic                  pos_bad;
	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;
	logic                  link_we;
	logic [IDX_W-1:0]      link_wa;
	logic [IDX_W-1:0]      link_wd;
	logic                  val_we;

	assign busy         = (state_q != S_IDLE);
	assign accept       = start && !busy;
	assign result       = result_q;
	assign result_valid = result_valid_q;

	assign req_value = VALUE_BITS'(request.value);
	assign req_pos   = IDX_W'(request.position);
	// position 0 and positions beyond the store are never on the list
	assign pos_bad   = (request.position == 7'd0)
		|| (32'(request.position) >= 32'(NODE_COUNT));

	// insert walks to its position, searches compare the stored value
	assign walk_hit = (action_q == cll_pkg::ACT_INSERT) ? (cur_q == pos_q)
		: (val_rd_q == value_q);

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = first_q;
		link_we = 1'b0;
		link_wa = cur_q;
		link_wd = plink_q;
		val_we  = 1'b0;
		unique case (state_q)
			S_INIT: begin
				link_we = 1'b1;
				link_wa = init_q;
				link_wd = (init_q == LAST_NODE) ? NULL_NODE : init_q + IDX_W'(1);
			end
			S_IDLE: begin
				// start fetching the first node right away
				rd_en   = accept && (first_q != NULL_NODE);
				rd_addr = first_q;
			end
			S_WALK: begin
				rd_en   = !walk_hit && (link_rd_q != NULL_NODE);
				rd_addr = link_rd_q;
			end
			S_INS_RD: begin
				// fetch the link of the node taken from the free list
				rd_en   = (free_q != NULL_NODE);
				rd_addr = free_q;
			end
			S_INS_LINK: begin
				link_we = 1'b1;
				link_wa = cur_q;
				link_wd = plink_q;
				val_we  = 1'b1;
			end
			S_INS_HOOK: begin
				link_we = (pos_q != HEADER_NODE);
				link_wa = pos_q;
				link_wd = cur_q;
			end
			S_RM_UNLINK: begin
				link_we = (prev_q != HEADER_NODE);
				link_wa = prev_q;
				link_wd = plink_q;
			end
			S_RM_FREE: begin
				link_we = 1'b1;
				link_wa = cur_q;
				link_wd = free_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (rd_en) begin
			link_rd_q <= link_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[cur_q] <= value_q;
		end
		if (rd_en) begin
			val_rd_q <= val_mem[rd_addr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_INIT;
			init_q         <= FIRST_FREE;
			free_q         <= FIRST_FREE;
			first_q        <= NULL_NODE;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + IDX_W'(1);
					if (init_q == LAST_NODE) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						action_q <= request.action;
						value_q  <= req_value;
						pos_q    <= req_pos;
						prev_q   <= HEADER_NODE;
						cur_q    <= first_q;
						result_q.result_position <= 7'd0;
						result_q.found           <= 1'b0;
						result_q.list_empty      <= (first_q == NULL_NODE);
						if (request.action == cll_pkg::ACT_INSERT) begin
							if (pos_bad) begin
								result_valid_q  <= 1'b1;
								result_q.status <= cll_pkg::ST_BAD_POS;
							end else if (req_pos == HEADER_NODE) begin
								// link after the header is the first node
								plink_q <= first_q;
								state_q <= S_INS_RD;
							end else if (first_q == NULL_NODE) begin
								result_valid_q  <= 1'b1;
								result_q.status <= cll_pkg::ST_BAD_POS;
							end else begin
								state_q <= S_WALK;
							end
						end else begin
							if (first_q == NULL_NODE) begin
								result_valid_q  <= 1'b1;
								result_q.status <= cll_pkg::ST_NOT_FOUND;
							end else begin
								state_q <= S_WALK;
							end
						end
					end
				end
				S_WALK: begin
					if (walk_hit) begin
						plink_q <= link_rd_q;
						case (action_q)
							cll_pkg::ACT_INSERT: begin
								state_q <= S_INS_RD;
							end
							cll_pkg::ACT_REMOVE: begin
								state_q <= S_RM_UNLINK;
							end
							default: begin
								// find or find previous: answer now
								result_valid_q           <= 1'b1;
								result_q.found           <= 1'b1;
								result_q.status          <= cll_pkg::ST_OK;
								result_q.result_position <=
									(action_q == cll_pkg::ACT_FIND) ? 7'(cur_q) : 7'(prev_q);
								state_q <= S_IDLE;
							end
						endcase
					end else if (link_rd_q == NULL_NODE) begin
						// end of list reached without a hit
						result_valid_q  <= 1'b1;
						result_q.status <= (action_q == cll_pkg::ACT_INSERT)
							? cll_pkg::ST_BAD_POS : cll_pkg::ST_NOT_FOUND;
						state_q <= S_IDLE;
					end else begin
						prev_q <= cur_q;
						cur_q  <= link_rd_q;
					end
				end
				S_INS_RD: begin
					if (free_q == NULL_NODE) begin
						result_valid_q  <= 1'b1;
						result_q.status <= cll_pkg::ST_FULL;
						state_q         <= S_IDLE;
					end else begin
						cur_q   <= free_q;
						state_q <= S_INS_LINK;
					end
				end
				S_INS_LINK: begin
					// pop the free list, new node points past the position
					free_q  <= link_rd_q;
					state_q <= S_INS_HOOK;
				end
				S_INS_HOOK: begin
					if (pos_q == HEADER_NODE) begin
						first_q <= cur_q;
					end
					result_valid_q           <= 1'b1;
					result_q.status          <= cll_pkg::ST_OK;
					result_q.result_position <= 7'(cur_q);
					result_q.list_empty      <= 1'b0;
					state_q                  <= S_IDLE;
				end
				S_RM_UNLINK: begin
					if (prev_q == HEADER_NODE) begin
						first_q <= plink_q;
					end
					state_q <= S_RM_FREE;
				end
				S_RM_FREE: begin
					// push the removed node onto the free list
					free_q                   <= cur_q;
					result_valid_q           <= 1'b1;
					result_q.found           <= 1'b1;
					result_q.status          <= cll_pkg::ST_OK;
					result_q.result_position <= 7'(cur_q);
					result_q.list_empty      <= (first_q == NULL_NODE);
					state_q                  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// free list and list never share a head node
	a_heads_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		(free_q != first_q) || (free_q == NULL_NODE))
		else $error("free list and list share a head node");

	// a found result always carries ok status
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.found) |-> (result.status == cll_pkg::ST_OK))
		else $error("found result without ok status");

	// an accepted request is either answered at once or keeps the engine busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || result_valid))
		else $error("accepted request dropped");

	// a successful insert never reports an empty list
	a_insert_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_HOOK) |=> (result_valid && !result.list_empty))
		else $error("insert left list empty");
`endif

endmodule

// File: dv/tb_cursor_linked_list_engine.sv
module tb_cursor_linked_list_engine;

	localparam int         NODES       = 128;
	localparam logic [6:0] FREE_HEAD   = 7'd0;
	localparam logic [6:0] HEAD_NODE   = 7'd1;
	localparam int         TOTAL_ITEMS = 1950;
	localparam int         CYCLE_LIMIT = 1_200_000;
	// a walk of the whole store plus write-back
	localparam int         SETTLE      = NODES + 20;

	typedef struct {
		cll_pkg::request_t req;
		bit                pinned;
		cll_pkg::result_t  res;
	} script_row_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	cll_pkg::request_t request;
	logic              result_valid;
	cll_pkg::result_t  result;

	// pinned expectation travels with the request
	bit               pin_use;
	cll_pkg::result_t pin_res;

	// mirror of the node store
	logic [6:0]  shadow_link [NODES];
	logic [31:0] shadow_value [NODES];

	cll_pkg::result_t results_due[$];
	int               taken_count;
	int               sent;
	int               fail_count;
	int               cycle_count;
	bit               no_gaps;

	cursor_linked_list_engine dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.result_valid(result_valid),
		.result      (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void log_failure(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] %s", $realtime, msg);
	endfunction

	function automatic void clear_shadow();
		for (int i = 0; i < NODES; i++) begin
			shadow_link[i] = (i + 1 < NODES) ? 7'(i + 1) : 7'd0;
			shadow_value[i] = '0;
		end
		shadow_link[FREE_HEAD] = 7'd2;
		shadow_link[HEAD_NODE] = 7'd0;
	endfunction

	// carries one request out on the mirror and returns the result it owes
	function automatic cll_pkg::result_t execute_on_shadow(cll_pkg::request_t r);
		cll_pkg::result_t res;
		logic [6:0]       cur;
		logic [6:0]       prev;
		logic [6:0]       pred;
		logic [6:0]       node;
		int               steps;
		bit               hit;
		res = '0;
		res.status = cll_pkg::ST_OK;
		if (r.action == cll_pkg::ACT_INSERT) begin
			// is the position the header or reachable from it
			hit = 1'b0;
			cur = HEAD_NODE;
			steps = 0;
			while (cur != 0 && !hit && steps <= NODES) begin
				if (cur == r.position)
					hit = 1'b1;
				else
					cur = shadow_link[cur];
				steps++;
			end
			if (r.position == 0 || !hit) begin
				res.status = cll_pkg::ST_BAD_POS;
			end else if (shadow_link[FREE_HEAD] == 0) begin
				res.status = cll_pkg::ST_FULL;
			end else begin
				node = shadow_link[FREE_HEAD];
				shadow_link[FREE_HEAD] = shadow_link[node];
				shadow_value[node] = r.value;
				shadow_link[node] = shadow_link[r.position];
				shadow_link[r.position] = node;
				res.result_position = node;
			end
		end else begin
			// first node holding the value, remembering its predecessor
			prev = HEAD_NODE;
			cur = shadow_link[HEAD_NODE];
			pred = 7'd0;
			steps = 0;
			while (cur != 0 && pred == 0 && steps < NODES) begin
				if (shadow_value[cur] == r.value) begin
					pred = prev;
				end else begin
					prev = cur;
					cur = shadow_link[cur];
				end
				steps++;
			end
			if (pred == 0) begin
				res.status = cll_pkg::ST_NOT_FOUND;
			end else begin
				res.found = 1'b1;
				node = shadow_link[pred];
				case (r.action)
					cll_pkg::ACT_FIND: begin
						res.result_position = node;
					end
					cll_pkg::ACT_FIND_PREV: begin
						res.result_position = pred;
					end
					default: begin
						shadow_link[pred] = shadow_link[node];
						shadow_link[node] = shadow_link[FREE_HEAD];
						shadow_link[FREE_HEAD] = node;
						res.result_position = node;
					end
				endcase
			end
		end
		res.list_empty = (shadow_link[HEAD_NODE] == 0);
		return res;
	endfunction

	// random request, mostly aimed at live nodes and values on the list
	function automatic cll_pkg::request_t draw_request(int insert_pct);
		cll_pkg::request_t r;
		logic [6:0]        nodes[$];
		logic [6:0]        cur;
		int                pick;
		cur = shadow_link[HEAD_NODE];
		while (cur != 0 && nodes.size() < NODES) begin
			nodes.push_back(cur);
			cur = shadow_link[cur];
		end
		if ($urandom_range(0, 99) < insert_pct) begin
			r.action = cll_pkg::ACT_INSERT;
		end else begin
			case ($urandom_range(0, 2))
				0:       r.action = cll_pkg::ACT_FIND;
				1:       r.action = cll_pkg::ACT_FIND_PREV;
				default: r.action = cll_pkg::ACT_REMOVE;
			endcase
		end
		pick = $urandom_range(0, nodes.size());
		if ($urandom_range(0, 99) < 85)
			r.position = (pick == 0) ? HEAD_NODE : nodes[pick - 1];
		else
			r.position = 7'($urandom_range(0, 127));
		pick = $urandom_range(0, 99);
		if (nodes.size() != 0 && pick < ((r.action == cll_pkg::ACT_INSERT) ? 15 : 65))
			r.value = shadow_value[nodes[$urandom_range(0, nodes.size() - 1)]];
		else if (pick < 80)
			r.value = 32'($urandom_range(0, 7));
		else
			r.value = $urandom;
		return r;
	endfunction

	// result check first, then take the new request: both may share an edge
	always @(posedge clk) begin
		cll_pkg::result_t want;
		if (arst_n) begin
			if (result_valid === 1'b1) begin
				if (results_due.size() == 0) begin
					log_failure($sformatf({"result with no request pending: ",
						"pos %0d found %0b status %0d empty %0b"},
						result.result_position, result.found, result.status,
						result.list_empty));
				end else begin
					want = results_due.pop_front();
					if (result.result_position !== want.result_position ||
					    result.found !== want.found ||
					    result.status !== want.status ||
					    result.list_empty !== want.list_empty)
						log_failure($sformatf({"result mismatch: expected pos %0d found %0b ",
							"status %0d empty %0b, got pos %0d found %0b status %0d empty %0b"},
							want.result_position, want.found, want.status, want.list_empty,
							result.result_position, result.found, result.status,
							result.list_empty));
				end
			end
			if (start && busy === 1'b0) begin
				want = execute_on_shadow(request);
				if (pin_use)
					want = pin_res;
				results_due.push_back(want);
				taken_count++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** cursor_linked_list_engine: FAILED **");
			$finish;
		end
	end

	// one request, after a random gap, held until the engine takes it
	task automatic issue(cll_pkg::request_t r, bit pin = 1'b0, cll_pkg::result_t pres = '0);
		int gap;
		int target;
		if (sent % 50 == 0)
			no_gaps = ($urandom_range(0, 3) == 0);
		gap = no_gaps ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		request <= r;
		pin_use <= pin;
		pin_res <= pres;
		start <= 1'b1;
		target = taken_count + 1;
		do @(negedge clk); while (taken_count < target);
		sent++;
	endtask

	task automatic hold_until_drained();
		start <= 1'b0;
		do @(negedge clk); while (results_due.size() != 0);
	endtask

	task automatic run_mixed(int count, int insert_pct);
		repeat (count) begin
			if ($urandom_range(0, 99) == 0)
				hold_until_drained();
			issue(draw_request(insert_pct));
		end
	endtask

	function automatic script_row_t row(logic [1:0] act, logic [31:0] val, logic [6:0] pos,
			bit pin = 1'b0, cll_pkg::result_t res = '0);
		script_row_t s;
		s.req.action = act;
		s.req.value = val;
		s.req.position = pos;
		s.pinned = pin;
		s.res = res;
		return s;
	endfunction

	initial begin
		script_row_t       script[$];
		cll_pkg::request_t rq;
		start = 1'b0;
		request = '0;
		pin_use = 1'b0;
		pin_res = '0;
		arst_n = 1'b0;
		taken_count = 0;
		sent = 0;
		fail_count = 0;
		cycle_count = 0;
		no_gaps = 1'b0;
		clear_shadow();

		// empty list, bad positions, then a short list with duplicates
		script.push_back(row(cll_pkg::ACT_FIND, 32'h0, 7'd0, 1,
			'{7'd0, 1'b0, cll_pkg::ST_NOT_FOUND, 1'b1}));
		script.push_back(row(cll_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 7'd127, 1,
			'{7'd0, 1'b0, cll_pkg::ST_NOT_FOUND, 1'b1}));
		script.push_back(row(cll_pkg::ACT_FIND_PREV, 32'h5, 7'd0, 1,
			'{7'd0, 1'b0, cll_pkg::ST_NOT_FOUND, 1'b1}));
		script.push_back(row(cll_pkg::ACT_INSERT, 32'h1, 7'd0, 1,
			'{7'd0, 1'b0, cll_pkg::ST_BAD_POS, 1'b1}));
		script.push_back(row(cll_pkg::ACT_INSERT, 32'h1, 7'd127, 1,
			'{7'd0, 1'b0, cll_pkg::ST_BAD_POS, 1'b1}));
		script.push_back(row(cll_pkg::ACT_INSERT, 32'h1, 7'd2, 1,
			'{7'd0, 1'b0, cll_pkg::ST_BAD_POS, 1'b1}));
		script.push_back(row(cll_pkg::ACT_INSERT, 32'h0, HEAD_NODE, 1,
			'{7'd2, 1'b0, cll_pkg::ST_OK, 1'b0}));
		script.push_back(row(cll_pkg::ACT_INSERT, 32'hFFFF_FFFF, HEAD_NODE, 1,
			'{7'd3, 1'b0, cll_pkg::ST_OK, 1'b0}));
		script.push_back(row(cll_pkg::ACT_INSERT, 32'h8000_0000, 7'd2, 1,
			'{7'd4, 1'b0, cll_pkg::ST_OK, 1'b0}));
		script.push_back(row(cll_pkg::ACT_FIND, 32'h0, 7'd0, 1,
			'{7'd2, 1'b1, cll_pkg::ST_OK, 1'b0}));
		script.push_back(row(cll_pkg::ACT_FIND_PREV, 32'h0, 7'd0, 1,
			'{7'd3, 1'b1, cll_pkg::ST_OK, 1'b0}));
		script.push_back(row(cll_pkg::ACT_FIND_PREV, 32'hFFFF_FFFF, 7'd0, 1,
			'{7'd1, 1'b1, cll_pkg::ST_OK, 1'b0}));
		script.push_back(row(cll_pkg::ACT_FIND, 32'h1234_5678, 7'd0, 1,
			'{7'd0, 1'b0, cll_pkg::ST_NOT_FOUND, 1'b0}));
		script.push_back(row(cll_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 7'd0, 1,
			'{7'd3, 1'b1, cll_pkg::ST_OK, 1'b0}));
		// a freed node is no longer a valid insert point
		script.push_back(row(cll_pkg::ACT_INSERT, 32'h9, 7'd3, 1,
			'{7'd0, 1'b0, cll_pkg::ST_BAD_POS, 1'b0}));
		script.push_back(row(cll_pkg::ACT_INSERT, 32'h0, 7'd4, 1,
			'{7'd3, 1'b0, cll_pkg::ST_OK, 1'b0}));
		// duplicate value: remove takes the first match
		script.push_back(row(cll_pkg::ACT_REMOVE, 32'h0, 7'd0, 1,
			'{7'd2, 1'b1, cll_pkg::ST_OK, 1'b0}));
		script.push_back(row(cll_pkg::ACT_FIND, 32'h0, 7'd0, 1,
			'{7'd3, 1'b1, cll_pkg::ST_OK, 1'b0}));
		script.push_back(row(cll_pkg::ACT_INSERT, 32'h7, HEAD_NODE));
		script.push_back(row(cll_pkg::ACT_FIND_PREV, 32'h8000_0000, 7'd0));
		script.push_back(row(cll_pkg::ACT_REMOVE, 32'h8000_0000, 7'd0));
		script.push_back(row(cll_pkg::ACT_REMOVE, 32'h0, 7'd0));
		script.push_back(row(cll_pkg::ACT_REMOVE, 32'h7, 7'd0));
		script.push_back(row(cll_pkg::ACT_FIND, 32'hFFFF_FFFF, 7'd0, 1,
			'{7'd0, 1'b0, cll_pkg::ST_NOT_FOUND, 1'b1}));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// busy covers the free chain sweep, so the first request just waits
		foreach (script[i])
			issue(script[i].req, script[i].pinned, script[i].res);
		hold_until_drained();

		run_mixed(400, 50);
		hold_until_drained();

		// fill the store, then knock on it while full
		while (shadow_link[FREE_HEAD] != 0)
			issue(draw_request(100));
		repeat (6)
			issue(draw_request(100));
		run_mixed(20, 30);
		hold_until_drained();

		// long walks on a nearly full list
		run_mixed(500, 25);
		hold_until_drained();

		// empty the list again
		while (shadow_link[HEAD_NODE] != 0) begin
			rq = draw_request(0);
			rq.action = cll_pkg::ACT_REMOVE;
			issue(rq);
		end
		hold_until_drained();

		while (sent < TOTAL_ITEMS)
			run_mixed(1, 45);

		hold_until_drained();
		repeat (SETTLE) @(negedge clk);
		if (results_due.size() != 0)
			log_failure($sformatf("%0d results never arrived", results_due.size()));
		if (fail_count == 0)
			$display("** cursor_linked_list_engine: PASSED **");
		else
			$display("** cursor_linked_list_engine: FAILED **");
		$finish;
	end

endmodule
